@@ sv/eeas_pkg.sv @@
// ----------------------------------------------------------------------------
// eeas_pkg
// Shared constants and tables for the eased elliptic arc stepper.
// ----------------------------------------------------------------------------
package eeas_pkg;

   // parameter defaults
   localparam int ANGLE_BITS_DEF     = 16;
   localparam int AXIS_FRAC_BITS_DEF = 8;

   // fixed field widths
   localparam int AXIS_W     = 14;
   localparam int STEP_W     = 4;
   localparam int INTERVAL_W = 8;
   localparam int POS_W      = 8;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_A        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_B        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_ANGLE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARC_START     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARC_SWEEP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TOTAL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_INTERVAL = 3'd6;

   // register reset values
   localparam logic [AXIS_W-1:0]     AXIS_A_RST        = 14'd3840;
   localparam logic [AXIS_W-1:0]     AXIS_B_RST        = 14'd2560;
   localparam logic [STEP_W-1:0]     STEP_TOTAL_RST    = 4'd6;
   localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST = 8'd15;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // cordic
   localparam int CORD_W     = 34;
   localparam int CORD_STEPS = 24;
   localparam int CORD_CNT_W = 5;
   localparam logic signed [CORD_W-1:0] CORD_GAIN = 34'sd652032874;
   localparam logic signed [CORD_W-1:0] QUARTER   = 34'sd1073741824;
   localparam logic signed [CORD_W-1:0] HALF      = 34'sd2147483648;

   // divider
   localparam int DIV_W     = 35;
   localparam int DIV_CNT_W = 6;

   // arctangent table in 2^32 turn units
   function automatic logic signed [CORD_W-1:0] atan_turn(input logic [CORD_CNT_W-1:0] i);
      logic signed [CORD_W-1:0] v;
      case (i)
         5'd0:    v = 34'sd536870912;
         5'd1:    v = 34'sd316933406;
         5'd2:    v = 34'sd167458907;
         5'd3:    v = 34'sd85004756;
         5'd4:    v = 34'sd42667331;
         5'd5:    v = 34'sd21354465;
         5'd6:    v = 34'sd10679838;
         5'd7:    v = 34'sd5340245;
         5'd8:    v = 34'sd2670163;
         5'd9:    v = 34'sd1335087;
         5'd10:   v = 34'sd667544;
         5'd11:   v = 34'sd333772;
         5'd12:   v = 34'sd166886;
         5'd13:   v = 34'sd83443;
         5'd14:   v = 34'sd41722;
         5'd15:   v = 34'sd20861;
         5'd16:   v = 34'sd10430;
         5'd17:   v = 34'sd5215;
         5'd18:   v = 34'sd2608;
         5'd19:   v = 34'sd1304;
         5'd20:   v = 34'sd652;
         5'd21:   v = 34'sd326;
         5'd22:   v = 34'sd163;
         5'd23:   v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/eased_elliptic_arc_stepper_top.sv @@
// ----------------------------------------------------------------------------
// eased_elliptic_arc_stepper_top
// Steps a pointer along a rotated elliptical arc with cosine easing.
// ----------------------------------------------------------------------------
// Usage: the req channel carries items (req_type: start or millisecond tick,
// req_sink_ready: report sink free). Every item yields exactly one rsp item
// (report_valid, delta_x, delta_y, move_done). Registers are written through
// csr_write_en / csr_index / csr_data; the user must write them only while
// the block is idle, which the block does not enforce. Start items, idle
// ticks and ticks inside the step interval pass from idle to the emit state.
// A tick that computes a step runs a bit-serial divider, three CORDIC passes
// (load, then rotations) on one shared rotator, one shared 32x32 multiplier
// and the emit state. One item is in flight at a time; a new item is taken
// while the previous result still sits in the rsp register. Reset
// (synchronous, active high) restores the register defaults, stops the move
// and empties the rsp register. When the receiver stalls, the rsp item holds
// and the block waits with its next result until the register frees.
// ----------------------------------------------------------------------------
module eased_elliptic_arc_stepper_top
   import eeas_pkg::*;
#(
   parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
   parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF,
   localparam int CSR_W = (ANGLE_BITS + 1 > AXIS_W) ? ANGLE_BITS + 1 : AXIS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic                   req_sink_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_report_valid,
   output logic signed [7:0]      rsp_delta_x,
   output logic signed [7:0]      rsp_delta_y,
   output logic                   rsp_move_done,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_CLD, S_CORD, S_AMUL, S_ANG, S_MUL, S_EMIT
   } state_type;

   // configuration registers
   logic [AXIS_W-1:0]            axis_a_ff, axis_b_ff;
   logic [ANGLE_BITS-1:0]        tilt_ff, start_ff;
   logic signed [ANGLE_BITS:0]   sweep_ff;
   logic [STEP_W-1:0]            total_ff;
   logic [INTERVAL_W-1:0]        interval_ff;

   // move state
   state_type                    state_ff;
   logic                         moving_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [POS_W-1:0]             pos_x_ff, pos_y_ff;
   logic [INTERVAL_W-1:0]        ms_ff;
   logic                         sink_ff;

   // pending result
   logic                         pend_rv_ff, pend_done_ff;
   logic signed [7:0]            pend_dx_ff, pend_dy_ff;

   // output register
   logic                         rsp_valid_ff, rsp_rv_ff, rsp_done_ff;
   logic signed [7:0]            rsp_dx_ff, rsp_dy_ff;

   // divider
   logic [DIV_W-1:0]             dq_ff;
   logic [STEP_W-1:0]            rem_ff;
   logic [DIV_CNT_W-1:0]         dcnt_ff;

   // cordic
   logic signed [CORD_W-1:0]     cx_ff, cy_ff, cz_ff;
   logic                         flip_ff;
   logic [CORD_CNT_W-1:0]        ccnt_ff;
   logic [1:0]                   cjob_ff;
   logic [31:0]                  turn_ff;

   // arithmetic operands and results
   logic signed [31:0]           e_ff, c_ff, s_ff, cr_ff, sr_ff, ex_ff, ey_ff;
   logic signed [63:0]           prod_ff, accx_ff, accy_ff;
   logic [2:0]                   mcnt_ff;

   // step decision on an accepted tick
   logic                         req_acc;
   logic [INTERVAL_W-1:0]        ms_in;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign ms_in     = (ms_ff != '1) ? ms_ff + 1'b1 : ms_ff;

   // output register loads from the emit state once it frees
   logic                         rsp_load;
   assign rsp_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // divider step
   logic [STEP_W:0]              div_r;
   logic                         div_q;
   logic [STEP_W:0]              div_sub;
   assign div_r   = {rem_ff, dq_ff[DIV_W-1]};
   assign div_sub = div_r - {1'b0, total_ff};
   assign div_q   = (div_r >= {1'b0, total_ff});

   // cordic rotation
   logic signed [CORD_W-1:0]     ysh, xsh, cres_x, cres_y;
   logic signed [CORD_W-1:0]     fz;
   logic                         fflip;
   assign ysh    = cy_ff >>> ccnt_ff;
   assign xsh    = cx_ff >>> ccnt_ff;
   assign cres_x = flip_ff ? -cx_ff : cx_ff;
   assign cres_y = flip_ff ? -cy_ff : cy_ff;

   // fold the angle into a quarter turn either side of zero
   always_comb begin
      fz    = CORD_W'($signed(turn_ff));
      fflip = 1'b0;
      if (fz > QUARTER) begin
         fz    = fz - HALF;
         fflip = 1'b1;
      end else if (fz < -QUARTER) begin
         fz    = fz + HALF;
         fflip = 1'b1;
      end
   end

   // shared multiplier operand select
   logic signed [31:0]           opa, opb;
   always_comb begin
      case (mcnt_ff)
         3'd0:    begin opa = 32'($signed({1'b0, axis_a_ff})); opb = c_ff; end
         3'd1:    begin opa = 32'($signed({1'b0, axis_b_ff})); opb = s_ff; end
         3'd2:    begin opa = ex_ff; opb = cr_ff; end
         3'd3:    begin opa = ey_ff; opb = sr_ff; end
         3'd4:    begin opa = ex_ff; opb = sr_ff; end
         3'd5:    begin opa = ey_ff; opb = cr_ff; end
         default: begin opa = 32'(sweep_ff); opb = e_ff; end
      endcase
   end

   // rounded products
   logic signed [63:0]           ex_rnd, ang_rnd, xq_rnd, yq_rnd, accy_sum;
   logic [31:0]                  angle;
   assign ex_rnd   = (prod_ff + (64'sd1 <<< (AXIS_FRAC_BITS + 13))) >>> (AXIS_FRAC_BITS + 14);
   assign ang_rnd  = (prod_ff + (64'sd1 <<< (ANGLE_BITS - 3))) >>> (ANGLE_BITS - 2);
   assign angle    = {start_ff, (32 - ANGLE_BITS)'(0)} + ang_rnd[31:0];
   assign accy_sum = accy_ff + prod_ff;
   assign xq_rnd   = (accx_ff + 64'sd536870912) >>> 30;
   assign yq_rnd   = (accy_sum + 64'sd536870912) >>> 30;

   // pixel deltas, rounded half away from zero and saturated
   function automatic logic signed [7:0] to_pix(input logic signed [63:0] q,
                                                input logic [POS_W-1:0] pos);
      logic signed [35:0] d;
      logic [35:0]        m;
      logic [35:0]        r;
      d = $signed(q[35:0]) - (36'($signed(pos)) <<< 16);
      m = d[35] ? 36'(-d) : 36'(d);
      r = (m + 36'd32768) >> 16;
      if (r > 36'd127) r = 36'd127;
      return d[35] ? -8'(r[7:0]) : 8'(r[7:0]);
   endfunction

   logic signed [7:0]            dx, dy;
   assign dx = to_pix(xq_rnd, pos_x_ff);
   assign dy = to_pix(yq_rnd, pos_y_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_a_ff   <= AXIS_A_RST;
         axis_b_ff   <= AXIS_B_RST;
         tilt_ff     <= '0;
         start_ff    <= '0;
         sweep_ff    <= '0;
         total_ff    <= STEP_TOTAL_RST;
         interval_ff <= STEP_INTERVAL_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_AXIS_A:        axis_a_ff   <= csr_data[AXIS_W-1:0];
            CSR_AXIS_B:        axis_b_ff   <= csr_data[AXIS_W-1:0];
            CSR_TILT_ANGLE:    tilt_ff     <= csr_data[ANGLE_BITS-1:0];
            CSR_ARC_START:     start_ff    <= csr_data[ANGLE_BITS-1:0];
            CSR_ARC_SWEEP:     sweep_ff    <= $signed(csr_data[ANGLE_BITS:0]);
            CSR_STEP_TOTAL:    total_ff    <= csr_data[STEP_W-1:0];
            CSR_STEP_INTERVAL: interval_ff <= csr_data[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer, datapath and result registers
   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      if (reset) begin
         state_ff     <= S_IDLE;
         moving_ff    <= 1'b0;
         step_ff      <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         ms_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         mcnt_ff      <= 3'd6;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  pend_rv_ff   <= 1'b0;
                  pend_dx_ff   <= '0;
                  pend_dy_ff   <= '0;
                  pend_done_ff <= 1'b0;
                  sink_ff      <= req_sink_ready;
                  state_ff     <= S_EMIT;
                  if (req_type == REQ_START) begin
                     moving_ff <= 1'b1;
                     step_ff   <= '0;
                     pos_x_ff  <= '0;
                     pos_y_ff  <= '0;
                     ms_ff     <= '0;
                  end else if (moving_ff) begin
                     ms_ff <= ms_in;
                     if (ms_in >= interval_ff) begin
                        if (step_ff >= total_ff) begin
                           moving_ff    <= 1'b0;
                           pend_done_ff <= 1'b1;
                        end else begin
                           dq_ff    <= {step_ff + 1'b1, 31'd0} + DIV_W'(total_ff >> 1);
                           rem_ff   <= '0;
                           dcnt_ff  <= '0;
                           state_ff <= S_DIV;
                        end
                     end
                  end
               end
            end
            // restoring division, one quotient bit a cycle
            S_DIV: begin
               rem_ff  <= div_q ? div_sub[STEP_W-1:0] : div_r[STEP_W-1:0];
               dq_ff   <= {dq_ff[DIV_W-2:0], div_q};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
                  turn_ff  <= {dq_ff[30:0], div_q};
                  cjob_ff  <= 2'd0;
                  state_ff <= S_CLD;
               end
            end
            // cordic load with fold
            S_CLD: begin
               cx_ff    <= CORD_GAIN;
               cy_ff    <= '0;
               cz_ff    <= fz;
               flip_ff  <= fflip;
               ccnt_ff  <= '0;
               state_ff <= S_CORD;
            end
            // one cordic micro-rotation a cycle
            S_CORD: begin
               if (ccnt_ff == CORD_CNT_W'(CORD_STEPS)) begin
                  case (cjob_ff)
                     2'd0: begin
                        e_ff     <= 32'((QUARTER - cres_x) >>> 1);
                        mcnt_ff  <= 3'd6;
                        state_ff <= S_AMUL;
                     end
                     2'd1: begin
                        c_ff     <= 32'(cres_x);
                        s_ff     <= 32'(cres_y);
                        turn_ff  <= {tilt_ff, (32 - ANGLE_BITS)'(0)};
                        cjob_ff  <= 2'd2;
                        state_ff <= S_CLD;
                     end
                     default: begin
                        cr_ff    <= 32'(cres_x);
                        sr_ff    <= 32'(cres_y);
                        mcnt_ff  <= 3'd0;
                        state_ff <= S_MUL;
                     end
                  endcase
               end else begin
                  ccnt_ff <= ccnt_ff + 1'b1;
                  if (!cz_ff[CORD_W-1]) begin
                     cx_ff <= cx_ff - ysh;
                     cy_ff <= cy_ff + xsh;
                     cz_ff <= cz_ff - atan_turn(ccnt_ff);
                  end else begin
                     cx_ff <= cx_ff + ysh;
                     cy_ff <= cy_ff - xsh;
                     cz_ff <= cz_ff + atan_turn(ccnt_ff);
                  end
               end
            end
            // sweep times easing sits in the product register
            S_AMUL: state_ff <= S_ANG;
            S_ANG: begin
               turn_ff  <= angle;
               cjob_ff  <= 2'd1;
               state_ff <= S_CLD;
            end
            // projection and rotation on the shared multiplier
            S_MUL: begin
               mcnt_ff <= mcnt_ff + 1'b1;
               case (mcnt_ff)
                  3'd1: ex_ff <= ex_rnd[31:0];
                  3'd2: ey_ff <= ex_rnd[31:0];
                  3'd3: accx_ff <= prod_ff;
                  3'd4: accx_ff <= accx_ff - prod_ff;
                  3'd5: accy_ff <= prod_ff;
                  3'd6: begin
                     state_ff <= S_EMIT;
                     if ((dx == 8'sd0 && dy == 8'sd0) || sink_ff) begin
                        pend_rv_ff <= (dx != 8'sd0) || (dy != 8'sd0);
                        pend_dx_ff <= dx;
                        pend_dy_ff <= dy;
                        step_ff    <= step_ff + 1'b1;
                        pos_x_ff   <= pos_x_ff + dx;
                        pos_y_ff   <= pos_y_ff + dy;
                        ms_ff      <= '0;
                     end
                  end
                  default: ;
               endcase
            end
            // hand the item to the output register once it frees
            S_EMIT: begin
               if (rsp_load) begin
                  rsp_rv_ff    <= pend_rv_ff;
                  rsp_dx_ff    <= pend_dx_ff;
                  rsp_dy_ff    <= pend_dy_ff;
                  rsp_done_ff  <= pend_done_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_valid = rsp_rv_ff;
   assign rsp_delta_x      = rsp_dx_ff;
   assign rsp_delta_y      = rsp_dy_ff;
   assign rsp_move_done    = rsp_done_ff;

   // a sent report always carries movement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_valid |-> (rsp_delta_x != 8'sd0) || (rsp_delta_y != 8'sd0))
      else $error("report without movement");

   // a move cannot end on the same item that sends a report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_move_done && rsp_report_valid))
      else $error("report and move end together");

   // an idle report carries zero deltas
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_delta_x == 8'sd0 && rsp_delta_y == 8'sd0)
      else $error("deltas without report");

   // the emit state leaves a result in the output register when the receiver does not stall
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && !rsp_stall |=> rsp_valid)
      else $error("result lost on emit");

endmodule

@@ tb/eased_elliptic_arc_stepper_top_tb.sv @@
// ----------------------------------------------------------------------------
// eased_elliptic_arc_stepper_top_tb
// Self-checking bench for the arc stepper: a directed table followed by
// random moves under many register settings. Each accepted item runs through
// a local fixed-point model of the stepper; every rsp item is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module eased_elliptic_arc_stepper_top_tb;
   import eeas_pkg::*;

   localparam int CSR_W = 17;

   typedef struct packed {
      logic              report_valid;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
      logic              move_done;
   } report_type;

   typedef struct {
      logic       typ;
      logic       sink;
      bit         typed;
      report_type rep;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_type = REQ_TICK;
   logic                 req_sink_ready = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_report_valid;
   logic signed [7:0]    rsp_delta_x;
   logic signed [7:0]    rsp_delta_y;
   logic                 rsp_move_done;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   eased_elliptic_arc_stepper_top u_dut (.*);

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model copy of registers and move state
   logic [13:0] m_axis_a, m_axis_b;
   logic [15:0] m_tilt, m_start;
   logic [16:0] m_sweep;
   logic [3:0]  m_total;
   logic [7:0]  m_interval;
   logic        m_moving;
   logic [3:0]  m_index;
   logic [7:0]  m_pos_x, m_pos_y, m_elapsed;

   report_type pending_reports[$];
   int      n_sent = 0;
   int      n_errors = 0;
   int      idle_mode = 0;

   // cordic sine / cosine of a 32 bit turn angle, q2.30
   task automatic cordic(input logic [31:0] turn, output longint c, output longint s);
      longint atab[24];
      longint z, x, y, t;
      bit flip;
      atab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
               10679838, 5340245, 2670163, 1335087, 667544, 333772,
               166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      z = longint'(signed'(turn));
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648; flip = 1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648; flip = 1;
      end
      for (int i = 0; i < 24; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atab[i];
         end else begin
            t = x + (y >>> i); y = y - (x >>> i); x = t; z += atab[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint rshift_round(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   // q16 target minus position, rounded half away from zero, saturated
   function automatic logic signed [7:0] pixel_delta(longint q16, logic [7:0] pos);
      longint d, m, r;
      d = q16 - longint'(signed'(pos)) * 65536;
      m = d < 0 ? -d : d;
      r = (m + 32768) >>> 16;
      if (r > 127) r = 127;
      return d < 0 ? 8'(-r) : 8'(r);
   endfunction

   // advance the stepper model by one item
   task automatic step_model(input logic typ, input logic sink, output report_type rep);
      logic [31:0] phase, angle, nxt;
      longint c, s, cr, sr, e, ex, ey, xq, yq;
      logic signed [7:0] dx, dy;
      rep = '0;
      if (typ == REQ_START) begin
         m_moving = 1; m_index = 0; m_pos_x = 0; m_pos_y = 0; m_elapsed = 0;
         return;
      end
      if (!m_moving) return;
      if (m_elapsed < 255) m_elapsed++;
      if (m_elapsed < m_interval) return;
      if (m_index >= m_total) begin
         m_moving = 0;
         rep.move_done = 1;
         return;
      end
      nxt = m_index + 1;
      phase = 32'(((longint'(nxt) << 31) + m_total / 2) / m_total);
      cordic(phase, c, s);
      e = (64'sd1073741824 - c) >>> 1;
      angle = (32'(m_start) << 16)
            + 32'(rshift_round(longint'(signed'(m_sweep)) * e, 14));
      cordic(angle, c, s);
      cordic(32'(m_tilt) << 16, cr, sr);
      ex = rshift_round(longint'(m_axis_a) * c, 22);
      ey = rshift_round(longint'(m_axis_b) * s, 22);
      xq = rshift_round(ex * cr - ey * sr, 30);
      yq = rshift_round(ex * sr + ey * cr, 30);
      dx = pixel_delta(xq, m_pos_x);
      dy = pixel_delta(yq, m_pos_y);
      if (dx != 0 || dy != 0) begin
         if (!sink) return;
         rep.report_valid = 1;
         rep.delta_x = dx;
         rep.delta_y = dy;
      end
      m_index = nxt[3:0];
      m_pos_x += dx;
      m_pos_y += dy;
      m_elapsed = 0;
   endtask

   // maybe idle for a random gap first, then offer one item and wait for acceptance
   task automatic send_item(input logic typ, input logic sink, output report_type rep);
      int gap_pct;
      idle_mode = n_sent < 500 ? 0 : (n_sent < 1000 ? 1 : 2);
      gap_pct = idle_mode == 0 ? 32 : (idle_mode == 1 ? 83 : 0);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_sink_ready <= sink;
      do @(posedge clock); while (req_stall);
      step_model(typ, sink, rep);
      pending_reports.push_back(rep);
      n_sent++;
   endtask

   // wait until every prediction has been matched
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write all registers, block idle
   task automatic write_regs(input logic [13:0] a, input logic [13:0] b,
                             input logic [15:0] tilt, input logic [15:0] start,
                             input logic [16:0] sweep, input logic [3:0] total,
                             input logic [7:0] interval);
      logic [CSR_W-1:0] vals[7];
      logic [CSR_IDX_W-1:0] idx[7];
      vals = '{17'(a), 17'(b), 17'(tilt), 17'(start), sweep, 17'(total), 17'(interval)};
      idx = '{CSR_AXIS_A, CSR_AXIS_B, CSR_TILT_ANGLE, CSR_ARC_START, CSR_ARC_SWEEP,
              CSR_STEP_TOTAL, CSR_STEP_INTERVAL};
      for (int i = 0; i < 7; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
      m_axis_a = a; m_axis_b = b; m_tilt = tilt; m_start = start;
      m_sweep = sweep; m_total = total; m_interval = interval;
   endtask

   // receiver: random stall, plus one long hold-off so the block backs up
   int  hold_left = 0;
   bit  hold_done = 0;
   always @(posedge clock) begin
      int pct;
      pct = idle_mode == 0 ? 83 : (idle_mode == 1 ? 32 : 0);
      if (!hold_done && n_sent >= 700) begin
         hold_done <= 1'b1;
         hold_left <= 400;
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected rsp item rv=%0d dx=%0d dy=%0d done=%0d", $time,
                     rsp_report_valid, rsp_delta_x, rsp_delta_y, rsp_move_done);
            n_errors++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_report_valid !== want.report_valid) begin
               $display("%0t: report_valid expected %0d actual %0d", $time,
                        want.report_valid, rsp_report_valid);
               n_errors++;
            end
            if (rsp_delta_x !== want.delta_x) begin
               $display("%0t: delta_x expected %0d actual %0d", $time,
                        want.delta_x, rsp_delta_x);
               n_errors++;
            end
            if (rsp_delta_y !== want.delta_y) begin
               $display("%0t: delta_y expected %0d actual %0d", $time,
                        want.delta_y, rsp_delta_y);
               n_errors++;
            end
            if (rsp_move_done !== want.move_done) begin
               $display("%0t: move_done expected %0d actual %0d", $time,
                        want.move_done, rsp_move_done);
               n_errors++;
            end
         end
      end
   end

   // directed table: idle tick, start, the interval, busy sink, retry, restart
   row_type table_rows[$];

   task automatic add_row(input logic typ, input logic sink, input bit typed);
      row_type r;
      r.typ = typ; r.sink = sink; r.typed = typed; r.rep = '0;
      table_rows.push_back(r);
   endtask

   // stimulus
   initial begin
      report_type got;
      logic [13:0] a, b;
      logic [16:0] sw;
      logic [3:0]  tot;
      logic [7:0]  ivl;
      int ticks, phase_no;

      m_axis_a = AXIS_A_RST; m_axis_b = AXIS_B_RST; m_tilt = 0; m_start = 0;
      m_sweep = 0; m_total = STEP_TOTAL_RST; m_interval = STEP_INTERVAL_RST;
      m_moving = 0; m_index = 0; m_pos_x = 0; m_pos_y = 0; m_elapsed = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zeros until the interval ends, then a busy sink
      add_row(REQ_TICK, 1'b1, 1);
      add_row(REQ_START, 1'b1, 1);
      for (int i = 0; i < 14; i++) add_row(REQ_TICK, 1'b1, 1);
      add_row(REQ_TICK, 1'b0, 1);
      add_row(REQ_TICK, 1'b1, 0);
      add_row(REQ_TICK, 1'b1, 1);
      add_row(REQ_START, 1'b0, 1);
      add_row(REQ_TICK, 1'b0, 1);
      foreach (table_rows[i]) begin
         send_item(table_rows[i].typ, table_rows[i].sink, got);
         if (table_rows[i].typed && got !== table_rows[i].rep) begin
            $display("%0t: table row %0d expected %h actual %h", $time, i,
                     table_rows[i].rep, got);
            n_errors++;
         end
      end
      drain();

      // unused register index is ignored
      csr_write_en <= 1'b1;
      csr_index <= 3'd7;
      csr_data <= '1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);

      // random moves under changing settings, extremes on early phases
      phase_no = 0;
      while (n_sent < 1500) begin
         case (phase_no)
            0: write_regs(14'h3FFF, 14'h3FFF, 16'hFFFF, 16'hFFFF, 17'h10000, 4'd15, 8'd0);
            1: write_regs(14'h0, 14'h0, 16'h0, 16'h0, 17'h0FFFF, 4'd0, 8'd1);
            2: write_regs(14'h3FFF, 14'h2000, 16'h4000, 16'h8000, 17'h0FFFF, 4'd1, 8'd255);
            3: write_regs(14'h1555, 14'h2AAA, 16'h5555, 16'hAAAA, 17'h15555, 4'd15, 8'd2);
            default: begin
               a = $urandom_range(3) == 0 ? 14'($urandom) : 14'($urandom_range(8000));
               b = $urandom_range(3) == 0 ? 14'($urandom) : 14'($urandom_range(8000));
               sw = 17'($urandom);
               tot = 4'($urandom_range(15));
               ivl = $urandom_range(7) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(3));
               if (ivl > 40) tot = 4'($urandom_range(2));
               write_regs(a, b, 16'($urandom), 16'($urandom), sw, tot, ivl);
            end
         endcase
         ticks = (m_interval + 1) * (m_total + 2) + $urandom_range(4);
         send_item(REQ_START, 1'($urandom), got);
         for (int i = 0; i < ticks && n_sent < 1600; i++) begin
            if ($urandom_range(99) < 3)
               send_item(REQ_START, 1'($urandom), got);
            else
               send_item(REQ_TICK, $urandom_range(99) < 80, got);
         end
         drain();
         phase_no++;
      end

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
      if (n_errors == 0 && pending_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
sv/eeas_pkg.sv
sv/eased_elliptic_arc_stepper_top.sv
tb/eased_elliptic_arc_stepper_top_tb.sv
